[sv/mpd_pkg.sv]
// Package for the marker packet deframer: types, codes and defaults.
`default_nettype none
package mpd_pkg;

  // Default build values
  localparam int MPD_MAX_PACKET = 20;
  localparam int MPD_IDLE_TICKS = 250;

  // Start marker byte '!'
  localparam logic [7:0] START_MARK = 8'h21;

  // Input command codes
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    STS_GOOD     = 2'd0,
    STS_NO_START = 2'd1,
    STS_BAD_SUM  = 2'd2
  } status_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_STOP_TYPE    = 3'd0,
    REG_STOP_LEN     = 3'd1,
    REG_CONTROL_TYPE = 3'd2,
    REG_CONTROL_LEN  = 3'd3,
    REG_KEY_TYPE     = 3'd4,
    REG_KEY_LEN      = 3'd5,
    REG_SPEED_TYPE   = 3'd6,
    REG_SPEED_LEN    = 3'd7
  } reg_idx_t;

  // Register reset values
  localparam logic [7:0] RST_STOP_TYPE    = 8'd83;
  localparam logic [7:0] RST_CONTROL_TYPE = 8'd67;
  localparam logic [7:0] RST_KEY_TYPE     = 8'd75;
  localparam logic [7:0] RST_SPEED_TYPE   = 8'd86;
  localparam logic [4:0] RST_LEN          = 5'd20;

  // Configuration register file contents
  typedef struct packed {
    logic [7:0] stop_type;
    logic [4:0] stop_len;
    logic [7:0] control_type;
    logic [4:0] control_len;
    logic [7:0] key_type;
    logic [4:0] key_len;
    logic [7:0] speed_type;
    logic [4:0] speed_len;
  } cfg_regs_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;     // input request taken this cycle
    logic load_err;   // load the error result into the output register
    logic load_good;  // load the current packet byte and step the read index
    logic clear;      // packet finished, return to empty
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic done;       // the offered request completes the packet
    logic bad;        // the held packet failed its checks
    logic out_free;   // output register can take a result this cycle
    logic last_idx;   // read index is at the final byte
  } dp_sts_t;

endpackage
`default_nettype wire

[sv/mpd_in_if.sv]
// Input channel: received bytes and millisecond ticks.
`default_nettype none
interface mpd_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface
`default_nettype wire

[sv/mpd_out_if.sv]
// Result channel: packet bytes or a single error result.
`default_nettype none
interface mpd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] data_byte;
  logic [4:0] position;
  logic [4:0] packet_length;
  logic       last;

  modport source (output valid, output status, output data_byte, output position,
                  output packet_length, output last, input ready);
  modport sink   (input valid, input status, input data_byte, input position,
                  input packet_length, input last, output ready);
endinterface
`default_nettype wire

[sv/mpd_cfg_regs.sv]
// Configuration register file for packet type codes and lengths.
`default_nettype none
module mpd_cfg_regs
  import mpd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_idx,
  input  wire logic [7:0] cfg_wdata,
  output cfg_regs_t       cfg_o
);

  cfg_regs_t regs_r, regs_nxt;

  // Register decode; lengths keep the low five bits
  always_comb begin
    regs_nxt = regs_r;
    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_STOP_TYPE:    regs_nxt.stop_type    = cfg_wdata;
        REG_STOP_LEN:     regs_nxt.stop_len     = cfg_wdata[4:0];
        REG_CONTROL_TYPE: regs_nxt.control_type = cfg_wdata;
        REG_CONTROL_LEN:  regs_nxt.control_len  = cfg_wdata[4:0];
        REG_KEY_TYPE:     regs_nxt.key_type     = cfg_wdata;
        REG_KEY_LEN:      regs_nxt.key_len      = cfg_wdata[4:0];
        REG_SPEED_TYPE:   regs_nxt.speed_type   = cfg_wdata;
        REG_SPEED_LEN:    regs_nxt.speed_len    = cfg_wdata[4:0];
        default:          regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.stop_type    <= RST_STOP_TYPE;
      regs_r.stop_len     <= RST_LEN;
      regs_r.control_type <= RST_CONTROL_TYPE;
      regs_r.control_len  <= RST_LEN;
      regs_r.key_type     <= RST_KEY_TYPE;
      regs_r.key_len      <= RST_LEN;
      regs_r.speed_type   <= RST_SPEED_TYPE;
      regs_r.speed_len    <= RST_LEN;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign cfg_o = regs_r;

endmodule
`default_nettype wire

[sv/mpd_datapath.sv]
// Datapath: packet store, running sum, counters, checks and output register.
`default_nettype none
module mpd_datapath
  import mpd_pkg::*;
#(
  parameter int MAX_PACKET = MPD_MAX_PACKET,
  parameter int IDLE_TICKS = MPD_IDLE_TICKS
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_regs_t  cfg_i,
  input  wire logic       in_cmd,
  input  wire logic [7:0] in_rx_byte,
  input  wire dp_cmd_t    cmd_i,
  output dp_sts_t         sts_o,
  input  wire logic       out_ready,
  output logic            out_valid,
  output logic [1:0]      out_status,
  output logic [7:0]      out_data_byte,
  output logic [4:0]      out_position,
  output logic [4:0]      out_packet_length,
  output logic            out_last
);

  localparam int CW = $clog2(MAX_PACKET + 1);
  localparam int IW = $clog2(MAX_PACKET);
  localparam int LW = (CW > 5) ? CW : 5;

  // Packet state
  logic [CW-1:0] count_r, count_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic [7:0]    type_r, type_nxt;
  logic [7:0]    timer_r, timer_nxt;
  logic [7:0]    last_r, last_nxt;
  logic          start_ok_r, start_ok_nxt;
  logic [IW-1:0] rd_idx_r, rd_idx_nxt;

  logic [7:0]    store_mem [MAX_PACKET];
  logic [7:0]    rd_data_r;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    status_r;
  logic [7:0]    data_r;
  logic [4:0]    pos_r;
  logic [4:0]    len_r;
  logic          last_flag_r;

  // Next-packet values for a byte request
  logic          is_mark;
  logic [CW-1:0] base_cnt;
  logic [CW-1:0] cnt_inc;
  logic [7:0]    base_sum;
  logic [7:0]    base_type;
  logic [7:0]    type_inc;
  logic [7:0]    timer_inc;
  logic          type_done;
  logic          len_done;
  logic          tick_done;
  logic [7:0]    sum_before;
  status_t       chk_status;

  assign is_mark   = (in_rx_byte == START_MARK);
  assign base_cnt  = is_mark ? '0 : count_r;
  assign base_sum  = is_mark ? 8'd0 : sum_r;
  assign base_type = is_mark ? 8'd0 : type_r;
  assign cnt_inc   = base_cnt + CW'(1);
  assign type_inc  = (base_cnt == CW'(1)) ? in_rx_byte : base_type;
  assign timer_inc = timer_r + 8'd1;

  // Completion by type length, by maximum length, or by idle timeout
  always_comb begin
    type_done = (cnt_inc >= CW'(2)) && (
      ((type_inc == cfg_i.stop_type)    && (LW'(cnt_inc) == LW'(cfg_i.stop_len))) ||
      ((type_inc == cfg_i.control_type) && (LW'(cnt_inc) == LW'(cfg_i.control_len))) ||
      ((type_inc == cfg_i.key_type)     && (LW'(cnt_inc) == LW'(cfg_i.key_len))) ||
      ((type_inc == cfg_i.speed_type)   && (LW'(cnt_inc) == LW'(cfg_i.speed_len))));
    len_done  = (cnt_inc == CW'(MAX_PACKET));
    tick_done = (count_r != '0) && (timer_inc >= 8'(IDLE_TICKS));
  end

  // Start marker and inverted-sum check on the held packet
  assign sum_before = sum_r - last_r;
  always_comb begin
    if (!start_ok_r) begin
      chk_status = STS_NO_START;
    end else if (~sum_before != last_r) begin
      chk_status = STS_BAD_SUM;
    end else begin
      chk_status = STS_GOOD;
    end
  end

  // Packet state update
  always_comb begin
    count_nxt    = count_r;
    sum_nxt      = sum_r;
    type_nxt     = type_r;
    timer_nxt    = timer_r;
    last_nxt     = last_r;
    start_ok_nxt = start_ok_r;
    rd_idx_nxt   = rd_idx_r;
    if (cmd_i.accept) begin
      if (in_cmd == CMD_BYTE) begin
        count_nxt    = cnt_inc;
        sum_nxt      = base_sum + in_rx_byte;
        type_nxt     = type_inc;
        timer_nxt    = 8'd0;
        last_nxt     = in_rx_byte;
        start_ok_nxt = (base_cnt == '0) ? is_mark : start_ok_r;
      end else if (count_r != '0) begin
        timer_nxt = timer_inc;
      end
    end
    if (cmd_i.load_good) begin
      rd_idx_nxt = rd_idx_r + IW'(1);
    end
    if (cmd_i.clear) begin
      count_nxt  = '0;
      sum_nxt    = 8'd0;
      type_nxt   = 8'd0;
      timer_nxt  = 8'd0;
      rd_idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      sum_r      <= 8'd0;
      type_r     <= 8'd0;
      timer_r    <= 8'd0;
      last_r     <= 8'd0;
      start_ok_r <= 1'b0;
      rd_idx_r   <= '0;
    end else begin
      count_r    <= count_nxt;
      sum_r      <= sum_nxt;
      type_r     <= type_nxt;
      timer_r    <= timer_nxt;
      last_r     <= last_nxt;
      start_ok_r <= start_ok_nxt;
      rd_idx_r   <= rd_idx_nxt;
    end
  end

  // Packet store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd_i.accept && (in_cmd == CMD_BYTE)) begin
      store_mem[base_cnt[IW-1:0]] <= in_rx_byte;
    end
    rd_data_r <= store_mem[rd_idx_r];
  end

  // Output register
  assign out_valid_nxt = (cmd_i.load_err || cmd_i.load_good) ? 1'b1 :
                         (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load_err) begin
      status_r    <= chk_status;
      data_r      <= 8'd0;
      pos_r       <= 5'd0;
      len_r       <= 5'(count_r);
      last_flag_r <= 1'b1;
    end else if (cmd_i.load_good) begin
      status_r    <= STS_GOOD;
      data_r      <= rd_data_r;
      pos_r       <= 5'(rd_idx_r);
      len_r       <= 5'(count_r);
      last_flag_r <= sts_o.last_idx;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_data_byte     = data_r;
  assign out_position      = pos_r;
  assign out_packet_length = len_r;
  assign out_last          = last_flag_r;

  // Status toward the controller
  always_comb begin
    sts_o.done     = (in_cmd == CMD_BYTE) ? (len_done || type_done) : tick_done;
    sts_o.bad      = (chk_status != STS_GOOD);
    sts_o.out_free = !out_valid_r || out_ready;
    sts_o.last_idx = ((CW'(rd_idx_r) + CW'(1)) == count_r);
  end

endmodule
`default_nettype wire

[sv/mpd_ctrl.sv]
// Controller state machine: collect, check, and read out a finished packet.
`default_nettype none
module mpd_ctrl
  import mpd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_COLLECT = 4'b0001,
    S_FINISH  = 4'b0010,
    S_EMIT_RD = 4'b0100,
    S_EMIT_WR = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd_o     = '0;
    unique case (state_r)
      S_COLLECT: begin
        in_ready     = 1'b1;
        cmd_o.accept = in_valid;
        if (in_valid && sts_i.done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!sts_i.bad) begin
          state_nxt = S_EMIT_RD;
        end else if (sts_i.out_free) begin
          cmd_o.load_err = 1'b1;
          cmd_o.clear    = 1'b1;
          state_nxt      = S_COLLECT;
        end
      end
      // store read data is registered, so it lands in the cycle after the index settles
      S_EMIT_RD: begin
        state_nxt = S_EMIT_WR;
      end
      S_EMIT_WR: begin
        if (sts_i.out_free) begin
          cmd_o.load_good = 1'b1;
          if (sts_i.last_idx) begin
            cmd_o.clear = 1'b1;
            state_nxt   = S_COLLECT;
          end else begin
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: state_nxt = S_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_COLLECT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

[sv/marker_packet_deframer.sv]
// Top level of the marker packet deframer.
`default_nettype none
// Takes one request per cycle (a received byte or a millisecond tick) while a
// packet is being collected; a '!' byte restarts the packet and byte 1 is its
// type. When a packet completes (configured length for its type, MAX_PACKET
// bytes, or IDLE_TICKS ticks without a byte) the input is held off: the start
// marker and inverted-sum checksum are checked, then either one error result
// is loaded, or each packet byte is read from the store and then loaded into
// the output register. The output register lets collection of the next packet
// start while the last result still waits to be taken. Configuration writes
// are registered and take effect in the cycle after the write.
module marker_packet_deframer
  import mpd_pkg::*;
#(
  parameter int MAX_PACKET = MPD_MAX_PACKET,
  parameter int IDLE_TICKS = MPD_IDLE_TICKS
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  mpd_in_if.sink          in_ch,
  mpd_out_if.source       out_ch,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_idx,
  input  wire logic [7:0] cfg_wdata
);

  cfg_regs_t cfg;
  dp_cmd_t   cmd;
  dp_sts_t   sts;

  mpd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  mpd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  mpd_datapath #(
    .MAX_PACKET (MAX_PACKET),
    .IDLE_TICKS (IDLE_TICKS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_i             (cfg),
    .in_cmd            (in_ch.cmd),
    .in_rx_byte        (in_ch.rx_byte),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_status        (out_ch.status),
    .out_data_byte     (out_ch.data_byte),
    .out_position      (out_ch.position),
    .out_packet_length (out_ch.packet_length),
    .out_last          (out_ch.last)
  );

  // No request is taken while a finished packet is being read out
  a_no_accept_during_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> !(cmd.load_err || cmd.load_good))
    else $error("request accepted during packet readout");

  // An error result is a single final result with a failing status
  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_err |=> (out_ch.valid && out_ch.last && (out_ch.status != STS_GOOD)))
    else $error("error result malformed");

  // Ending a packet always presents its final result
  a_clear_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (out_ch.valid && out_ch.last))
    else $error("packet cleared without final result");

endmodule
`default_nettype wire

[tb/deframer_tb_pkg.sv]
// Expected-result tracking for the marker packet deframer bench.
`timescale 1ns / 100ps
package deframer_tb_pkg;
  import mpd_pkg::*;

  // One result beat as seen on the output channel
  typedef struct {
    status_t    status;
    logic [7:0] data_byte;
    logic [4:0] position;
    logic [4:0] packet_length;
    logic       last;
  } frame_result_t;

  class deframer_scoreboard;
    // Register copy, slots in order stop, control, key, speed
    logic [7:0]    type_code[4];
    logic [4:0]    type_len[4];
    // Packet being collected
    logic [7:0]    frame_buf[MPD_MAX_PACKET];
    int unsigned   frame_cnt;
    logic [7:0]    frame_sum;
    logic [7:0]    frame_type;
    int unsigned   idle_ticks;
    frame_result_t pending_results[$];
    int unsigned   errors;

    function new();
      type_code  = '{RST_STOP_TYPE, RST_CONTROL_TYPE, RST_KEY_TYPE, RST_SPEED_TYPE};
      type_len   = '{RST_LEN, RST_LEN, RST_LEN, RST_LEN};
      frame_cnt  = 0;
      frame_sum  = 0;
      frame_type = 0;
      idle_ticks = 0;
      errors     = 0;
    endfunction

    // Lengths keep only their low five bits
    function void write_reg(reg_idx_t idx, logic [7:0] value);
      case (idx)
        REG_STOP_TYPE:    type_code[0] = value;
        REG_STOP_LEN:     type_len[0]  = value[4:0];
        REG_CONTROL_TYPE: type_code[1] = value;
        REG_CONTROL_LEN:  type_len[1]  = value[4:0];
        REG_KEY_TYPE:     type_code[2] = value;
        REG_KEY_LEN:      type_len[2]  = value[4:0];
        REG_SPEED_TYPE:   type_code[3] = value;
        default:          type_len[3]  = value[4:0];
      endcase
    endfunction

    // Any slot whose type and length both match closes the packet
    function bit length_hit();
      if (frame_cnt < 2) return 0;
      for (int k = 0; k < 4; k++)
        if (frame_type == type_code[k] && frame_cnt == type_len[k]) return 1;
      return 0;
    endfunction

    // Byte count at which a packet of this type closes under the current registers
    function int unsigned closing_length(logic [7:0] ftype);
      int unsigned n;
      n = MPD_MAX_PACKET;
      for (int k = 0; k < 4; k++)
        if (ftype == type_code[k] && type_len[k] >= 2 && type_len[k] < n) n = type_len[k];
      return n;
    endfunction

    // Start marker is checked before the checksum
    function void close_frame();
      frame_result_t r;
      logic [7:0]    tail;
      logic [7:0]    head_sum;
      status_t       st;
      tail     = frame_buf[frame_cnt - 1];
      head_sum = frame_sum - tail;
      if (frame_buf[0] != START_MARK) st = STS_NO_START;
      else if (~head_sum != tail) st = STS_BAD_SUM;
      else st = STS_GOOD;
      if (st != STS_GOOD) begin
        r.status        = st;
        r.data_byte     = 8'h00;
        r.position      = 5'd0;
        r.packet_length = frame_cnt[4:0];
        r.last          = 1'b1;
        pending_results.push_back(r);
      end else begin
        for (int unsigned i = 0; i < frame_cnt; i++) begin
          r.status        = STS_GOOD;
          r.data_byte     = frame_buf[i];
          r.position      = i[4:0];
          r.packet_length = frame_cnt[4:0];
          r.last          = (i + 1 == frame_cnt);
          pending_results.push_back(r);
        end
      end
      frame_cnt  = 0;
      frame_sum  = 0;
      frame_type = 0;
      idle_ticks = 0;
    endfunction

    // Advance the packet state by one accepted request
    function void collect_request(logic cmd, logic [7:0] rx);
      if (cmd == CMD_BYTE) begin
        if (rx == START_MARK) begin
          frame_cnt  = 0;
          frame_sum  = 0;
          frame_type = 0;
        end
        frame_buf[frame_cnt] = rx;
        if (frame_cnt == 1) frame_type = rx;
        frame_cnt++;
        frame_sum += rx;
        idle_ticks = 0;
        if (frame_cnt >= MPD_MAX_PACKET || length_hit()) close_frame();
      end else if (frame_cnt != 0) begin
        // ticks on an empty packet do nothing
        idle_ticks++;
        if (idle_ticks >= MPD_IDLE_TICKS) close_frame();
      end
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $error("unexpected result: status %0d data %02h position %0d length %0d",
               got.status, got.data_byte, got.position, got.packet_length);
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) begin
        errors++;
        $error("status: expected %0d, actual %0d", want.status, got.status);
      end
      if (got.data_byte !== want.data_byte) begin
        errors++;
        $error("data_byte: expected %02h, actual %02h", want.data_byte, got.data_byte);
      end
      if (got.position !== want.position) begin
        errors++;
        $error("position: expected %0d, actual %0d", want.position, got.position);
      end
      if (got.packet_length !== want.packet_length) begin
        errors++;
        $error("packet_length: expected %0d, actual %0d", want.packet_length,
               got.packet_length);
      end
      if (got.last !== want.last) begin
        errors++;
        $error("last: expected %0b, actual %0b", want.last, got.last);
      end
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction

    function bit collecting();
      return frame_cnt != 0;
    endfunction
  endclass

endpackage

[tb/tb_top.sv]
// Top-level bench for the marker packet deframer: stimulus, result monitor, end of run.
`timescale 1ns / 100ps
module tb_top;
  import mpd_pkg::*;
  import deframer_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned SETTLE_CYCLES = 2 * MPD_MAX_PACKET + 24;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned PHASE_BYTES   = 40;

  typedef enum {FR_GOOD, FR_BAD_SUM, FR_NO_START, FR_CUT, FR_NOISE} frame_kind_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [2:0] cfg_idx;
  logic [7:0] cfg_wdata;

  mpd_in_if  in_ch();
  mpd_out_if out_ch();

  marker_packet_deframer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  deframer_scoreboard sb;
  frame_result_t      seen;
  int unsigned        cycle_cnt  = 0;
  int unsigned        burst_left = 0;
  int unsigned        bytes_sent = 0;
  bit                 hold_req   = 1'b0;

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("marker_packet_deframer regression: fail");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen.status        = status_t'(out_ch.status);
      seen.data_byte     = out_ch.data_byte;
      seen.position      = out_ch.position;
      seen.packet_length = out_ch.packet_length;
      seen.last          = out_ch.last;
      sb.check_result(seen);
    end
  end

  // Receiver: segments of random stall rate, plus one long hold-off on request
  initial begin
    int unsigned seg_left;
    int unsigned stall_pct;
    out_ch.ready = 1'b0;
    seg_left     = 0;
    stall_pct    = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (seg_left == 0) begin
        stall_pct = 25 * $urandom_range(0, 3);
        seg_left  = $urandom_range(8, 80);
      end
      seg_left--;
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // One request; called and returns at a falling edge
  task automatic push_item(logic cmd, logic [7:0] rx);
    int unsigned gap;
    in_ch.valid   <= 1'b1;
    in_ch.cmd     <= cmd;
    in_ch.rx_byte <= rx;
    do @(posedge clk); while (!in_ch.ready);
    sb.collect_request(cmd, rx);
    if (cmd == CMD_BYTE) bytes_sent++;
    @(negedge clk);
    // bursts of random length, some without gaps between them
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic tick_run(int unsigned n);
    repeat (n) push_item(CMD_TICK, 8'($urandom()));
  endtask

  // Sender pauses until every expected result is out, then lets the block go quiet
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    sb.write_reg(idx, value);
    @(negedge clk);
  endtask

  // Upper bits of the length writes are junk and must be dropped
  task automatic load_config(cfg_regs_t c);
    write_reg(REG_STOP_TYPE,    c.stop_type);
    write_reg(REG_STOP_LEN,     {3'($urandom()), c.stop_len});
    write_reg(REG_CONTROL_TYPE, c.control_type);
    write_reg(REG_CONTROL_LEN,  {3'($urandom()), c.control_len});
    write_reg(REG_KEY_TYPE,     c.key_type);
    write_reg(REG_KEY_LEN,      {3'($urandom()), c.key_len});
    write_reg(REG_SPEED_TYPE,   c.speed_type);
    write_reg(REG_SPEED_LEN,    {3'($urandom()), c.speed_len});
    cfg_we <= 1'b0;
  endtask

  // One packet shaped to close at the length its type calls for, or cut short and closed by timeout, or noise bytes
  task automatic send_frame(frame_kind_t kind);
    logic [7:0]  ftype;
    logic [7:0]  sum;
    logic [7:0]  b;
    int unsigned len;
    int unsigned cut;
    if (kind == FR_NOISE) begin
      repeat ($urandom_range(1, 8)) push_item(CMD_BYTE, 8'($urandom()));
      return;
    end
    if ($urandom_range(0, 9) < 7) ftype = sb.type_code[$urandom_range(0, 3)];
    else ftype = 8'($urandom());
    if (ftype == START_MARK) ftype = ~ftype;
    len = sb.closing_length(ftype);
    cut = (kind == FR_CUT) ? $urandom_range(1, len - 1) : len;
    sum = 8'h00;
    for (int unsigned i = 0; i < cut; i++) begin
      if (i == 0) begin
        b = (kind == FR_NO_START) ? 8'($urandom()) : START_MARK;
        if (kind == FR_NO_START && b == START_MARK) b = ~b;
      end else if (i == 1) begin
        b = ftype;
      end else begin
        b = 8'($urandom());
        if (b == START_MARK) b = ~b;
      end
      if (i == len - 1 && i >= 2) begin
        b = ~sum;
        if (kind == FR_BAD_SUM) b ^= 8'($urandom_range(1, 255));
      end
      // short silence inside the packet, well below the timeout
      if (i > 0 && $urandom_range(0, 7) == 0) tick_run($urandom_range(1, 3));
      push_item(CMD_BYTE, b);
      sum += b;
    end
    if (kind == FR_CUT) tick_run(MPD_IDLE_TICKS);
  endtask

  function automatic frame_kind_t pick_kind();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return FR_GOOD;
    if (roll < 70) return FR_BAD_SUM;
    if (roll < 78) return FR_NO_START;
    if (roll < 84) return FR_CUT;
    return FR_NOISE;
  endfunction

  function automatic cfg_regs_t random_config();
    cfg_regs_t c;
    logic [7:0] types[4];
    logic [4:0] lens[4];
    // a shared type code now and then so that several slots match
    for (int k = 0; k < 4; k++) begin
      types[k] = ($urandom_range(0, 3) == 0) ? 8'h41 : 8'($urandom());
      if ($urandom_range(0, 9) < 8) lens[k] = 5'($urandom_range(2, 12));
      else lens[k] = 5'($urandom_range(0, 31));
    end
    c = '{stop_type: types[0], stop_len: lens[0], control_type: types[1],
          control_len: lens[1], key_type: types[2], key_len: lens[2],
          speed_type: types[3], speed_len: lens[3]};
    return c;
  endfunction

  // Registers, then random packets, then close any open packet by timeout
  task automatic run_phase(cfg_regs_t c, bit with_hold);
    int unsigned start;
    load_config(c);
    if (with_hold) hold_req = 1'b1;
    start = bytes_sent;
    while (bytes_sent - start < PHASE_BYTES) send_frame(pick_kind());
    if (sb.collecting()) tick_run(MPD_IDLE_TICKS);
    settle_block();
  endtask

  initial begin
    sb            = new();
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = REG_STOP_TYPE;
    cfg_wdata     = 8'h00;
    in_ch.valid   = 1'b0;
    in_ch.cmd     = CMD_BYTE;
    in_ch.rx_byte = 8'h00;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: short type lengths, a shared type, a length beyond the maximum
    load_config('{stop_type: 8'hDE, stop_len: 5'd2, control_type: 8'h00,
                  control_len: 5'd3, key_type: 8'hFF, key_len: 5'd31,
                  speed_type: 8'hFF, speed_len: 5'd4});
    // tick on an empty packet is ignored
    push_item(CMD_TICK, 8'hFF);
    // two-byte packet whose type byte is also its checksum
    push_item(CMD_BYTE, START_MARK);
    push_item(CMD_BYTE, 8'hDE);
    // type 0x00, three bytes
    push_item(CMD_BYTE, START_MARK);
    push_item(CMD_BYTE, 8'h00);
    push_item(CMD_BYTE, 8'hDE);
    // type 0xFF sits in two slots; the in-range length closes it
    push_item(CMD_BYTE, START_MARK);
    push_item(CMD_BYTE, 8'hFF);
    push_item(CMD_BYTE, 8'h00);
    push_item(CMD_BYTE, 8'hDF);
    // bad checksum
    push_item(CMD_BYTE, START_MARK);
    push_item(CMD_BYTE, 8'h00);
    push_item(CMD_BYTE, 8'h00);
    // no start marker and a bad checksum: start marker error wins
    push_item(CMD_BYTE, 8'h00);
    push_item(CMD_BYTE, 8'h00);
    push_item(CMD_BYTE, 8'h00);
    // start marker in mid packet restarts it
    push_item(CMD_BYTE, START_MARK);
    push_item(CMD_BYTE, 8'hFF);
    push_item(CMD_BYTE, START_MARK);
    push_item(CMD_BYTE, 8'hDE);
    // idle time one tick short of the timeout, twice, each cleared by a byte
    push_item(CMD_BYTE, 8'hFF);
    tick_run(MPD_IDLE_TICKS - 1);
    push_item(CMD_BYTE, 8'h00);
    tick_run(MPD_IDLE_TICKS - 1);
    push_item(CMD_BYTE, 8'h00);
    // single-byte packets closed by timeout: checksum against 0xFF, then no start
    push_item(CMD_BYTE, START_MARK);
    tick_run(MPD_IDLE_TICKS);
    push_item(CMD_BYTE, 8'hFF);
    tick_run(MPD_IDLE_TICKS);
    settle_block();

    // Random phases: reset values, mid values with a long receiver hold-off,
    // extremes, then random settings
    run_phase('{stop_type: RST_STOP_TYPE, stop_len: RST_LEN,
                control_type: RST_CONTROL_TYPE, control_len: RST_LEN,
                key_type: RST_KEY_TYPE, key_len: RST_LEN,
                speed_type: RST_SPEED_TYPE, speed_len: RST_LEN}, 1'b0);
    run_phase('{stop_type: 8'h53, stop_len: 5'd2, control_type: 8'h43,
                control_len: 5'd5, key_type: 8'h4B, key_len: 5'd11,
                speed_type: 8'h56, speed_len: 5'd20}, 1'b1);
    run_phase('{stop_type: 8'h00, stop_len: 5'd0, control_type: 8'hFF,
                control_len: 5'd31, key_type: 8'h00, key_len: 5'd1,
                speed_type: 8'h7F, speed_len: 5'd21}, 1'b0);
    repeat (3) run_phase(random_config(), 1'b0);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("marker_packet_deframer regression: pass");
    end else begin
      $display("marker_packet_deframer regression: fail");
    end
    $finish;
  end

endmodule
